>>> rtl/ntcm_pkg.sv
// Shared types, constants and helper functions for the neural transistor current model.
// No dependencies; every other file imports this package.
package ntcm_pkg;

  localparam int FIELD_W     = 24;
  localparam int ADDR_IN_W   = 15;
  localparam int STORE_DEPTH = 32768;
  localparam int WADDR_W     = 17;
  localparam int GS_W        = 26;
  localparam int CS_W        = 31;
  localparam int S_TDATA_W   = 136;
  localparam int M_TDATA_W   = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int OFF_ADDR  = 0;
  localparam int OFF_WVAL  = 15;
  localparam int OFF_TG    = 39;
  localparam int OFF_BG    = 63;
  localparam int OFF_DV    = 87;
  localparam int OFF_WIDTH = 111;

  localparam int VAL_W  = 32;
  localparam int OPA_W  = 33;
  localparam int OPB_W  = 33;
  localparam int PROD_W = 66;
  localparam int ACC_W  = 74;
  localparam int FRAC   = 16;
  localparam int RND_W  = ACC_W - FRAC;

  localparam logic signed [OPB_W-1:0] ONE_Q = 33'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GATE_SHIFT  = 3'd0,
    REG_GATE_INV    = 3'd1,
    REG_DRAIN_INV   = 3'd2,
    REG_CUR_SCALE   = 3'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_FEAT_G, PH_FEAT_V,
    PH_L0_S, PH_L0_T, PH_L0_E,
    PH_L1_S, PH_L1_T, PH_L1_E,
    PH_L2_S, PH_L2_T, PH_L2_E,
    PH_OUT_P, PH_OUT_Q, PH_OUT_C
  } phase_t;

  typedef enum logic [2:0] {
    ST_ISSUE, ST_DRAIN, ST_WB0, ST_WB1, ST_WB2, ST_WB3
  } step_t;

  typedef enum logic [2:0] {
    A_WEIGHT, A_GATE, A_DRAIN, A_SACT, A_P, A_Q
  } asel_t;

  typedef enum logic [3:0] {
    B_SV, B_TV, B_TP, B_VG, B_VD, B_T2, B_GIS, B_DIS, B_TACT, B_CS, B_WIDTH
  } bsel_t;

  typedef struct packed {
    logic               valid;
    logic               first;
    logic               bias;
    asel_t              a_sel;
    bsel_t              b_sel;
    logic [WADDR_W-1:0] waddr;
  } iss_t;

  // tanh sampled at steps of 1/4 from 0 to 4, unsigned Q0.16
  function automatic logic [15:0] tanh_entry(input logic [4:0] i);
    logic [15:0] v;
    unique case (i)
      5'd0:  v = 16'd0;
      5'd1:  v = 16'd16051;
      5'd2:  v = 16'd30285;
      5'd3:  v = 16'd41625;
      5'd4:  v = 16'd49912;
      5'd5:  v = 16'd55593;
      5'd6:  v = 16'd59320;
      5'd7:  v = 16'd61694;
      5'd8:  v = 16'd63179;
      5'd9:  v = 16'd64096;
      5'd10: v = 16'd64659;
      5'd11: v = 16'd65003;
      5'd12: v = 16'd65212;
      5'd13: v = 16'd65339;
      5'd14: v = 16'd65417;
      5'd15: v = 16'd65464;
      5'd16: v = 16'd65492;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [RND_W-1:0] x);
    logic [RND_W-VAL_W:0] hi;
    hi = x[RND_W-1:VAL_W-1];
    if ((&hi) || !(|hi)) return x[VAL_W-1:0];
    else if (x[RND_W-1]) return {1'b1, {(VAL_W-1){1'b0}}};
    else return {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

  function automatic logic [M_TDATA_W-1:0] sat48(input logic signed [RND_W-1:0] x);
    logic [RND_W-M_TDATA_W:0] hi;
    hi = x[RND_W-1:M_TDATA_W-1];
    if ((&hi) || !(|hi)) return x[M_TDATA_W-1:0];
    else if (x[RND_W-1]) return {1'b1, {(M_TDATA_W-1){1'b0}}};
    else return {1'b0, {(M_TDATA_W-1){1'b1}}};
  endfunction

  function automatic logic signed [VAL_W-1:0] add_sat32(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    s = (VAL_W+1)'(a) + (VAL_W+1)'(b);
    if (s[VAL_W] == s[VAL_W-1]) return s[VAL_W-1:0];
    else if (s[VAL_W]) return {1'b1, {(VAL_W-1){1'b0}}};
    else return {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

endpackage

>>> rtl/neural_transistor_current_model.sv
// Top level of the neural transistor current model: weight store, layer vectors,
// operand selection and write-back. Uses ntcm_pkg, ntcm_ctrl, ntcm_mac and ntcm_act.
//
// Usage:
//   s_* carries input beats. s_tuser is the op: 0 writes one weight into the store,
//   1 evaluates the model on the voltages and width in s_tdata.
//   m_* carries one result beat (drain current, signed Q32.16) per evaluation.
//   cfg_* writes the four scaling registers; write only while the block is idle.
// Timing:
//   s_tready stays high through a weight write.
//   An evaluation holds s_tready low until its result enters the output register.
//   The single multiply-accumulate unit sets how long: every term of every neuron
//   passes through it, and each neuron then waits for the unit to drain and for
//   write-back through the activation unit.
// Reset: synchronous; clears the sequencer, the output valid and restores the
//   scaling registers. The weight store is not cleared and must be loaded first.
// Stall: a result waits in the output register while m_tready is low; the block
//   accepts new beats meanwhile, and a later evaluation holds its last step until
//   the output register is free.
module neural_transistor_current_model
  import ntcm_pkg::*;
#(
  parameter int HIDDEN       = 64,
  parameter int WEIGHT_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // weight_addr[14:0], weight_value[38:15], top_gate_v[62:39], back_gate_v[86:63],
  // drain_v[110:87], width_factor[134:111], zero pad [135]
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // op[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // drain_current[47:0]
  output logic [M_TDATA_W-1:0]  m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;

  logic signed [FIELD_W-1:0] gate_shift;
  logic [FIELD_W-1:0]        gate_inv_scale;
  logic [FIELD_W-1:0]        drain_inv_scale;
  logic [CS_W-1:0]           current_scale;

  logic signed [FIELD_W-1:0] tg;
  logic signed [FIELD_W-1:0] bg;
  logic signed [FIELD_W-1:0] dv;
  logic [FIELD_W-1:0]        width;
  logic signed [GS_W-1:0]    gate_sum;

  logic [WEIGHT_WIDTH-1:0]   store [STORE_DEPTH];
  logic [WEIGHT_WIDTH-1:0]   wq;
  logic signed [VAL_W-1:0]   wext;

  logic signed [VAL_W-1:0]   sp_mem [HIDDEN];
  logic signed [VAL_W-1:0]   tp_mem [HIDDEN];
  logic signed [VAL_W-1:0]   sv_mem [HIDDEN];
  logic signed [VAL_W-1:0]   tv_mem [HIDDEN];
  logic signed [VAL_W-1:0]   sp_q;
  logic signed [VAL_W-1:0]   tp_q;
  logic signed [VAL_W-1:0]   sv_q;
  logic signed [VAL_W-1:0]   tv_q;

  logic signed [VAL_W-1:0]   vg;
  logic signed [VAL_W-1:0]   vd;
  logic signed [VAL_W-1:0]   e_reg;
  logic signed [VAL_W-1:0]   s2;
  logic signed [VAL_W-1:0]   t2;
  logic signed [VAL_W-1:0]   s_act;
  logic signed [VAL_W-1:0]   t_act;
  logic signed [VAL_W-1:0]   p_reg;
  logic signed [VAL_W-1:0]   q_reg;

  phase_t                    phase;
  step_t                     step;
  logic [IDX_W-1:0]          r;
  logic [IDX_W-1:0]          vidx;
  iss_t                      iss;

  logic                      rd_valid;
  logic                      rd_first;
  logic                      rd_bias;
  logic                      rd_oob;
  asel_t                     rd_asel;
  bsel_t                     rd_bsel;
  logic signed [OPA_W-1:0]   op_a;
  logic signed [OPB_W-1:0]   op_b;
  logic                      mac_busy;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [RND_W-1:0]   rnd;
  logic signed [VAL_W-1:0]   res32;

  logic                      in_beat;
  logic                      out_free;
  logic                      l2_emb;
  logic                      emb_wb;
  logic                      act_sig;
  logic signed [VAL_W-1:0]   act_x;
  logic signed [VAL_W-1:0]   act_y;

  assign s_tready  = (phase == PH_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign l2_emb    = (phase == PH_L2_E);
  assign emb_wb    = (phase == PH_L0_E) || (phase == PH_L1_E) || l2_emb;

  // configuration and captured operands
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_shift      <= 24'sd13107;
      gate_inv_scale  <= 24'd163840;
      drain_inv_scale <= 24'd218453;
      current_scale   <= 31'd30006320;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GATE_SHIFT: gate_shift      <= cfg_data[FIELD_W-1:0];
        REG_GATE_INV:   gate_inv_scale  <= cfg_data[FIELD_W-1:0];
        REG_DRAIN_INV:  drain_inv_scale <= cfg_data[FIELD_W-1:0];
        REG_CUR_SCALE:  current_scale   <= cfg_data[CS_W-1:0];
        default: ;
      endcase
    end
    if (in_beat && s_tuser) begin
      tg    <= s_tdata[OFF_TG +: FIELD_W];
      bg    <= s_tdata[OFF_BG +: FIELD_W];
      dv    <= s_tdata[OFF_DV +: FIELD_W];
      width <= s_tdata[OFF_WIDTH +: FIELD_W];
    end
  end

  assign gate_sum = GS_W'(tg) + GS_W'(bg) - GS_W'(gate_shift) - GS_W'(gate_shift);
  assign wext     = VAL_W'($signed(s_tdata[OFF_WVAL +: FIELD_W]));

  // weight store: one write, one registered read
  always_ff @(posedge clk) begin
    if (in_beat && !s_tuser) begin
      store[s_tdata[OFF_ADDR +: ADDR_IN_W]] <= wext[WEIGHT_WIDTH-1:0];
    end
    wq <= store[iss.waddr[ADDR_IN_W-1:0]];
  end

  // term pipeline stage between issue and MAC
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= iss.valid;
    end
    rd_first <= iss.first;
    rd_bias  <= iss.bias;
    rd_oob   <= (iss.waddr >= WADDR_W'(STORE_DEPTH));
    rd_asel  <= iss.a_sel;
    rd_bsel  <= iss.b_sel;
  end

  // layer vectors
  always_ff @(posedge clk) begin
    if (step == ST_WB0 && (phase == PH_L0_S || phase == PH_L1_S)) sp_mem[r] <= res32;
    sp_q <= sp_mem[vidx];
  end

  always_ff @(posedge clk) begin
    if (step == ST_WB0 && (phase == PH_L0_T || phase == PH_L1_T)) tp_mem[r] <= res32;
    tp_q <= tp_mem[vidx];
  end

  always_ff @(posedge clk) begin
    if (step == ST_WB2 && emb_wb && !l2_emb) sv_mem[r] <= act_y;
    sv_q <= sv_mem[vidx];
  end

  always_ff @(posedge clk) begin
    if (step == ST_WB3 && emb_wb && !l2_emb) tv_mem[r] <= act_y;
    tv_q <= tv_mem[vidx];
  end

  // operand selection
  always_comb begin
    unique case (rd_asel)
      A_WEIGHT: op_a = rd_oob ? '0 : OPA_W'($signed(wq));
      A_GATE:   op_a = OPA_W'(gate_sum);
      A_DRAIN:  op_a = OPA_W'(dv);
      A_SACT:   op_a = OPA_W'(s_act);
      A_P:      op_a = OPA_W'(p_reg);
      A_Q:      op_a = OPA_W'(q_reg);
      default:  op_a = '0;
    endcase
    if (rd_bias) begin
      op_b = ONE_Q;
    end else begin
      unique case (rd_bsel)
        B_SV:    op_b = OPB_W'(sv_q);
        B_TV:    op_b = OPB_W'(tv_q);
        B_TP:    op_b = OPB_W'(tp_q);
        B_VG:    op_b = OPB_W'(vg);
        B_VD:    op_b = OPB_W'(vd);
        B_T2:    op_b = OPB_W'(t2);
        B_GIS:   op_b = OPB_W'($signed({1'b0, gate_inv_scale}));
        B_DIS:   op_b = OPB_W'($signed({1'b0, drain_inv_scale}));
        B_TACT:  op_b = OPB_W'(t_act);
        B_CS:    op_b = OPB_W'($signed({1'b0, current_scale}));
        B_WIDTH: op_b = OPB_W'($signed({1'b0, width}));
        default: op_b = '0;
      endcase
    end
  end

  ntcm_ctrl #(
    .HIDDEN (HIDDEN)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (in_beat && s_tuser),
    .pipe_idle (!rd_valid && !mac_busy),
    .out_free  (out_free),
    .phase     (phase),
    .step      (step),
    .r         (r),
    .vidx      (vidx),
    .iss       (iss)
  );

  ntcm_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_valid),
    .first    (rd_first),
    .a        (op_a),
    .b        (op_b),
    .busy     (mac_busy),
    .acc      (acc)
  );

  // round half up from Q.32 to Q.16
  assign acc_r = acc + ACC_W'(32768);
  assign rnd   = RND_W'(acc_r >>> FRAC);
  assign res32 = sat32(rnd);

  // sigmoid on the first act step, tanh on the second
  assign act_sig = (step == ST_WB1);
  assign act_x   = act_sig ? add_sat32(l2_emb ? s2 : sp_q, e_reg) : (l2_emb ? t2 : tp_q);

  ntcm_act u_act (
    .clk      (clk),
    .sig_mode (act_sig),
    .x        (act_x),
    .y        (act_y)
  );

  // scalar write-back
  always_ff @(posedge clk) begin
    if (step == ST_WB0) begin
      unique case (phase)
        PH_FEAT_G: vg <= res32;
        PH_FEAT_V: vd <= res32;
        PH_L0_E, PH_L1_E, PH_L2_E: e_reg <= res32;
        PH_L2_S:   s2 <= res32;
        PH_L2_T:   t2 <= res32;
        PH_OUT_P:  p_reg <= res32;
        PH_OUT_Q:  q_reg <= res32;
        default: ;
      endcase
    end
    if (l2_emb && step == ST_WB2) s_act <= act_y;
    if (l2_emb && step == ST_WB3) t_act <= act_y;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (phase == PH_OUT_C && step == ST_WB0 && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (phase == PH_OUT_C && step == ST_WB0 && out_free) m_tdata <= sat48(rnd);
  end

endmodule

>>> rtl/ntcm_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate.
// Depends on ntcm_pkg.
module ntcm_mac
  import ntcm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     first,
  input  logic signed [OPA_W-1:0]  a,
  input  logic signed [OPB_W-1:0]  b,
  output logic                     busy,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod;
  logic                     pv;
  logic                     pfirst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= in_valid;
    end
    prod   <= a * b;
    pfirst <= first;
    if (pv) begin
      acc <= pfirst ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  assign busy = pv;

endmodule

>>> rtl/ntcm_act.sv
// Activation unit: tanh by table interpolation, sigmoid as (tanh(x/2)+1)/2.
// Registered output. Depends on ntcm_pkg.
module ntcm_act
  import ntcm_pkg::*;
(
  input  logic                    clk,
  input  logic                    sig_mode,
  input  logic signed [VAL_W-1:0] x,
  output logic signed [VAL_W-1:0] y
);

  logic signed [VAL_W:0] xh;
  logic [VAL_W:0]        ax;
  logic [3:0]            idx;
  logic [13:0]           frac;
  logic [15:0]           t_lo;
  logic [15:0]           t_hi;
  logic [15:0]           diff;
  logic [29:0]           prod;
  logic [16:0]           mag;
  logic signed [17:0]    th;
  logic signed [18:0]    sg;

  always_comb begin
    xh   = sig_mode ? ((33'(x) + 33'sd1) >>> 1) : 33'(x);
    ax   = xh[VAL_W] ? 33'(-xh) : 33'(xh);
    idx  = ax[17:14];
    frac = ax[13:0];
    t_lo = tanh_entry({1'b0, idx});
    t_hi = tanh_entry({1'b0, idx} + 5'd1);
    diff = t_hi - t_lo;
    prod = 30'(diff) * 30'(frac);
    if (ax >= 33'd262144) begin
      mag = 17'(tanh_entry(5'd16));
    end else begin
      mag = 17'(t_lo) + 17'((prod + 30'd8192) >> 14);
    end
    th = xh[VAL_W] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    sg = (19'(th) + 19'sd65537) >>> 1;
  end

  always_ff @(posedge clk) begin
    y <= sig_mode ? VAL_W'(sg) : VAL_W'(th);
  end

endmodule

>>> rtl/ntcm_ctrl.sv
// Sequencer: walks the layers neuron by neuron, issues MAC terms, runs write-back steps.
// Depends on ntcm_pkg.
module ntcm_ctrl
  import ntcm_pkg::*;
#(
  parameter int HIDDEN = 64,
  localparam int IDX_W = (HIDDEN > 1) ? $clog2(HIDDEN) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             pipe_idle,
  input  logic             out_free,
  output phase_t           phase,
  output step_t            step,
  output logic [IDX_W-1:0] r,
  output logic [IDX_W-1:0] vidx,
  output iss_t             iss
);

  localparam int KW = $clog2(HIDDEN + 2);
  localparam int H  = HIDDEN;
  localparam int HH = HIDDEN * HIDDEN;
  localparam logic [WADDR_W-1:0] A_S0W = WADDR_W'(0);
  localparam logic [WADDR_W-1:0] A_S0B = WADDR_W'(H);
  localparam logic [WADDR_W-1:0] A_T0W = WADDR_W'(2 * H);
  localparam logic [WADDR_W-1:0] A_E0W = WADDR_W'(3 * H);
  localparam logic [WADDR_W-1:0] A_E0B = WADDR_W'(3 * H + HH);
  localparam logic [WADDR_W-1:0] A_S1W = WADDR_W'(4 * H + HH);
  localparam logic [WADDR_W-1:0] A_S1B = WADDR_W'(4 * H + 2 * HH);
  localparam logic [WADDR_W-1:0] A_T1W = WADDR_W'(5 * H + 2 * HH);
  localparam logic [WADDR_W-1:0] A_E1W = WADDR_W'(5 * H + 3 * HH);
  localparam logic [WADDR_W-1:0] A_E1B = WADDR_W'(5 * H + 4 * HH);
  localparam logic [WADDR_W-1:0] A_S2W = WADDR_W'(6 * H + 4 * HH);
  localparam logic [WADDR_W-1:0] A_S2B = WADDR_W'(7 * H + 4 * HH);
  localparam logic [WADDR_W-1:0] A_T2W = WADDR_W'(7 * H + 4 * HH + 1);
  localparam logic [WADDR_W-1:0] A_E2W = WADDR_W'(8 * H + 4 * HH + 1);
  localparam logic [WADDR_W-1:0] A_E2B = WADDR_W'(8 * H + 4 * HH + 2);

  phase_t             phase_next;
  phase_t             phase_after;
  step_t              step_next;
  logic [KW-1:0]      k;
  logic [KW-1:0]      k_next;
  logic [KW-1:0]      n_val;
  logic [KW-1:0]      last_k;
  logic [IDX_W-1:0]   r_next;
  logic [WADDR_W-1:0] r_ext;
  logic [WADDR_W-1:0] r_times_h;
  logic [WADDR_W-1:0] row_base;
  logic [WADDR_W-1:0] bias_addr;
  logic               has_bias;
  logic               wide;
  logic               loop_ph;
  logic               emb_ph;
  logic               r_last;
  asel_t              a_sel;
  bsel_t              b_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      step  <= ST_ISSUE;
      k     <= '0;
      r     <= '0;
    end else begin
      phase <= phase_next;
      step  <= step_next;
      k     <= k_next;
      r     <= r_next;
    end
  end

  // job decode for the neuron in hand
  always_comb begin
    r_ext     = WADDR_W'(r);
    r_times_h = WADDR_W'(r_ext * WADDR_W'(H));
    row_base  = '0;
    bias_addr = '0;
    has_bias  = 1'b0;
    wide      = 1'b0;
    a_sel     = A_WEIGHT;
    b_sel     = B_SV;
    loop_ph   = 1'b0;
    emb_ph    = 1'b0;
    phase_after = PH_IDLE;
    unique case (phase)
      PH_IDLE: begin
        phase_after = PH_IDLE;
      end
      PH_FEAT_G: begin
        a_sel = A_GATE; b_sel = B_GIS; phase_after = PH_FEAT_V;
      end
      PH_FEAT_V: begin
        a_sel = A_DRAIN; b_sel = B_DIS; phase_after = PH_L0_S;
      end
      PH_L0_S: begin
        row_base = A_S0W + r_ext; bias_addr = A_S0B + r_ext; has_bias = 1'b1;
        b_sel = B_VG; loop_ph = 1'b1; phase_after = PH_L0_T;
      end
      PH_L0_T: begin
        row_base = A_T0W + r_ext; b_sel = B_VD; loop_ph = 1'b1; phase_after = PH_L0_E;
      end
      PH_L0_E: begin
        row_base = A_E0W + r_times_h; bias_addr = A_E0B + r_ext; has_bias = 1'b1;
        wide = 1'b1; b_sel = B_TP; loop_ph = 1'b1; emb_ph = 1'b1; phase_after = PH_L1_S;
      end
      PH_L1_S: begin
        row_base = A_S1W + r_times_h; bias_addr = A_S1B + r_ext; has_bias = 1'b1;
        wide = 1'b1; b_sel = B_SV; loop_ph = 1'b1; phase_after = PH_L1_T;
      end
      PH_L1_T: begin
        row_base = A_T1W + r_times_h; wide = 1'b1; b_sel = B_TV; loop_ph = 1'b1;
        phase_after = PH_L1_E;
      end
      PH_L1_E: begin
        row_base = A_E1W + r_times_h; bias_addr = A_E1B + r_ext; has_bias = 1'b1;
        wide = 1'b1; b_sel = B_TP; loop_ph = 1'b1; emb_ph = 1'b1; phase_after = PH_L2_S;
      end
      PH_L2_S: begin
        row_base = A_S2W; bias_addr = A_S2B; has_bias = 1'b1; wide = 1'b1; b_sel = B_SV;
        phase_after = PH_L2_T;
      end
      PH_L2_T: begin
        row_base = A_T2W; wide = 1'b1; b_sel = B_TV; phase_after = PH_L2_E;
      end
      PH_L2_E: begin
        row_base = A_E2W; bias_addr = A_E2B; has_bias = 1'b1; b_sel = B_T2; emb_ph = 1'b1;
        phase_after = PH_OUT_P;
      end
      PH_OUT_P: begin
        a_sel = A_SACT; b_sel = B_TACT; phase_after = PH_OUT_Q;
      end
      PH_OUT_Q: begin
        a_sel = A_P; b_sel = B_CS; phase_after = PH_OUT_C;
      end
      PH_OUT_C: begin
        a_sel = A_Q; b_sel = B_WIDTH; phase_after = PH_IDLE;
      end
      default: begin
        phase_after = PH_IDLE;
      end
    endcase
    n_val  = wide ? KW'(H) : KW'(1);
    last_k = has_bias ? n_val : n_val - KW'(1);
    r_last = (r == IDX_W'(H - 1));
  end

  // next state
  always_comb begin
    phase_next = phase;
    step_next  = step;
    k_next     = k;
    r_next     = r;
    priority if (phase == PH_IDLE) begin
      step_next = ST_ISSUE;
      k_next    = '0;
      r_next    = '0;
      if (start) phase_next = PH_FEAT_G;
    end else begin
      unique case (step)
        ST_ISSUE: begin
          if (k == last_k) begin
            step_next = ST_DRAIN;
            k_next    = '0;
          end else begin
            k_next = k + KW'(1);
          end
        end
        ST_DRAIN: begin
          if (pipe_idle) step_next = ST_WB0;
        end
        ST_WB0, ST_WB1, ST_WB2, ST_WB3: begin
          priority if (step == ST_WB0 && emb_ph) begin
            step_next = ST_WB1;
          end else if (step == ST_WB1) begin
            step_next = ST_WB2;
          end else if (step == ST_WB2) begin
            step_next = ST_WB3;
          end else if (phase == PH_OUT_C && !out_free) begin
            step_next = step;
          end else begin
            step_next = ST_ISSUE;
            if (loop_ph && !r_last) begin
              r_next = r + IDX_W'(1);
            end else begin
              r_next     = '0;
              phase_next = phase_after;
            end
          end
        end
        default: step_next = ST_ISSUE;
      endcase
    end
  end

  // outputs
  always_comb begin
    iss.valid = (phase != PH_IDLE) && (step == ST_ISSUE);
    iss.first = (k == '0);
    iss.bias  = has_bias && (k == n_val);
    iss.a_sel = a_sel;
    iss.b_sel = b_sel;
    iss.waddr = iss.bias ? bias_addr : row_base + WADDR_W'(k);
    vidx      = (step == ST_ISSUE) ? k[IDX_W-1:0] : r;
  end

endmodule

>>> rtl/ntcm_checker.sv
// Port-level checks for the neural transistor current model, bound to the top level.
// Depends on ntcm_pkg.
module ntcm_props
  import ntcm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

  // an evaluate beat makes the block busy
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> !s_tready)
    else $error("ready after evaluate beat");

  // a weight write gives no result
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser && !m_tvalid) |=> !m_tvalid)
    else $error("result after weight write");

  // a result only appears at the end of an evaluation
  a_out_from_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without evaluation");

endmodule

bind neural_transistor_current_model ntcm_props u_ntcm_props (.*);

>>> tb/ntcm_checker.sv
// Checker for the neural transistor current model: watches the weight-load, evaluate,
// config and result channels, predicts each drain current and compares. Uses ntcm_pkg.
module ntcm_checker
  import ntcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_TDATA_W-1:0]  m_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int H    = 64;
  localparam int S0W  = 0;
  localparam int S0B  = H;
  localparam int T0W  = 2 * H;
  localparam int E0W  = 3 * H;
  localparam int E0B  = 3 * H + H * H;
  localparam int S1W  = 4 * H + H * H;
  localparam int S1B  = 4 * H + 2 * H * H;
  localparam int T1W  = 5 * H + 2 * H * H;
  localparam int E1W  = 5 * H + 3 * H * H;
  localparam int E1B  = 5 * H + 4 * H * H;
  localparam int S2W  = 6 * H + 4 * H * H;
  localparam int S2B  = 7 * H + 4 * H * H;
  localparam int T2W  = 7 * H + 4 * H * H + 1;
  localparam int E2W  = 8 * H + 4 * H * H + 1;
  localparam int E2B  = 8 * H + 4 * H * H + 2;

  typedef longint vec_t [H];

  longint tanh_pts [17] = '{0, 16051, 30285, 41625, 49912, 55593, 59320, 61694, 63179,
                            64096, 64659, 65003, 65212, 65339, 65417, 65464, 65492};

  longint weights [STORE_DEPTH];
  longint shift_r, gis_r, dis_r, cscale_r;
  logic [M_TDATA_W-1:0] current_q [$];

  function automatic longint round_sh(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint x, int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
  endfunction

  function automatic longint tanh_fx(longint x);
    longint ax, y, i, f;
    ax = x < 0 ? -x : x;
    if (ax >= 4 * 65536) y = tanh_pts[16];
    else begin
      i = ax >>> 14;
      f = ax & 16383;
      y = tanh_pts[i] + (((tanh_pts[i + 1] - tanh_pts[i]) * f + 8192) >>> 14);
    end
    return x < 0 ? -y : y;
  endfunction

  function automatic longint sigm_fx(longint x);
    return (tanh_fx(round_sh(x, 1)) + 65536 + 1) >>> 1;
  endfunction

  function automatic longint dot_row(int row, bit has_b, int baddr, vec_t v, int n);
    longint acc;
    acc = has_b ? weights[baddr] * 65536 : 0;
    for (int k = 0; k < n; k++) acc += weights[row + k] * v[k];
    return clip(round_sh(acc, 16), 32);
  endfunction

  function automatic longint drain_current(longint tg, longint bg, longint dv, longint wf);
    vec_t sp, tp, sv, tv, ev, ft;
    longint vg, vd, s2, t2, e2, p, q;
    vg = clip(round_sh((tg - shift_r) * gis_r + (bg - shift_r) * gis_r, 16), 32);
    vd = clip(round_sh(dv * dis_r, 16), 32);
    for (int r = 0; r < H; r++) begin
      ft[0] = vg;
      sp[r] = dot_row(S0W + r, 1, S0B + r, ft, 1);
      ft[0] = vd;
      tp[r] = dot_row(T0W + r, 0, 0, ft, 1);
    end
    for (int r = 0; r < H; r++) ev[r] = dot_row(E0W + r * H, 1, E0B + r, tp, H);
    for (int r = 0; r < H; r++) begin
      sv[r] = sigm_fx(clip(sp[r] + ev[r], 32));
      tv[r] = tanh_fx(tp[r]);
    end
    for (int r = 0; r < H; r++) begin
      sp[r] = dot_row(S1W + r * H, 1, S1B + r, sv, H);
      tp[r] = dot_row(T1W + r * H, 0, 0, tv, H);
    end
    for (int r = 0; r < H; r++) ev[r] = dot_row(E1W + r * H, 1, E1B + r, tp, H);
    for (int r = 0; r < H; r++) begin
      sv[r] = sigm_fx(clip(sp[r] + ev[r], 32));
      tv[r] = tanh_fx(tp[r]);
    end
    s2 = dot_row(S2W, 1, S2B, sv, H);
    t2 = dot_row(T2W, 0, 0, tv, H);
    ft[0] = t2;
    e2 = dot_row(E2W, 1, E2B, ft, 1);
    s2 = sigm_fx(clip(s2 + e2, 32));
    t2 = tanh_fx(t2);
    p = round_sh(s2 * t2, 16);
    q = round_sh(p * cscale_r, 16);
    return clip(round_sh(q * wf, 16), 48);
  endfunction

  initial begin
    foreach (weights[i]) weights[i] = 0;
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    logic [M_TDATA_W-1:0] want;
    if (rst) begin
      shift_r  <= 13107;
      gis_r    <= 163840;
      dis_r    <= 218453;
      cscale_r <= 30006320;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_GATE_SHIFT: shift_r  <= longint'($signed(cfg_data[23:0]));
          REG_GATE_INV:   gis_r    <= longint'(cfg_data[23:0]);
          REG_DRAIN_INV:  dis_r    <= longint'(cfg_data[23:0]);
          REG_CUR_SCALE:  cscale_r <= longint'(cfg_data[30:0]);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (!s_tuser)
          weights[s_tdata[OFF_ADDR +: ADDR_IN_W]] = longint'($signed(s_tdata[OFF_WVAL +: 24]));
        else
          current_q.push_back(drain_current(longint'($signed(s_tdata[OFF_TG +: 24])),
                                            longint'($signed(s_tdata[OFF_BG +: 24])),
                                            longint'($signed(s_tdata[OFF_DV +: 24])),
                                            longint'(s_tdata[OFF_WIDTH +: 24])));
      end
      if (m_tvalid && m_tready) begin
        if (current_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %h", m_tdata);
        end else begin
          want = current_q.pop_front();
          if (want !== m_tdata) begin
            errors++;
            if (errors <= 10)
              $display("drain_current mismatch: expected %h got %h", want, m_tdata);
          end
        end
      end
      pending = current_q.size();
    end
  end
endmodule

>>> tb/testbench.sv
// Top of the testbench: clock, reset, weight loading, evaluations, config phases and
// handshake pressure. Instantiates neural_transistor_current_model and ntcm_checker.
module testbench
  import ntcm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int USED  = 8 * 64 + 4 * 64 * 64 + 3;
  localparam int S2B_A = 7 * 64 + 4 * 64 * 64;
  localparam int T2W_A = S2B_A + 1;

  logic                  clk = 0;
  logic                  rst;
  logic                  s_tvalid, s_tready, s_tuser;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  m_tvalid, m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors, pending;
  int                    burst_left = 0;
  bit                    hold_go = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  neural_transistor_current_model dut (.*);
  ntcm_checker chk (.*);

  task automatic send(input logic op, input logic [14:0] addr, input logic [23:0] wval,
                      input logic [23:0] tg, input logic [23:0] bg, input logic [23:0] dv,
                      input logic [23:0] wf);
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, wf, dv, bg, tg, wval, addr};
    @(posedge clk iff s_tready);
    if (burst_left > 0) burst_left--;
    else begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic load(input int addr, input int val);
    send(1'b0, addr[14:0], val[23:0], 24'($urandom), 24'($urandom), 24'($urandom),
         24'($urandom));
  endtask

  task automatic evaluate(input int tg, input int bg, input int dv, input int wf);
    send(1'b1, 15'($urandom), 24'($urandom), tg[23:0], bg[23:0], dv[23:0], wf[23:0]);
  endtask

  function automatic int volt();
    // mostly within a few volts, sometimes anywhere in range
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 24'hFFFFFF));
    return int'($urandom_range(0, 393216)) - 196608;
  endfunction

  task automatic rand_eval();
    evaluate(volt(), volt(), volt(), $urandom_range(0, 3) == 0 ?
             $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 262144));
  endtask

  task automatic settle();
    s_tvalid <= 0;
    burst_left = 0;
    @(posedge clk iff pending == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // receiver: ready mode is redrawn at random from three patterns; one long hold-off on request
  initial begin
    int cyc, mode;
    cyc = 0;
    mode = 0;
    m_tready <= 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        m_tready <= 0;
        repeat (45000) @(posedge clk);
        hold_go = 0;
      end else begin
        cyc++;
        if (cyc % 256 == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: m_tready <= 1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= cyc[0];
        endcase
      end
    end
  end

  initial begin
    s_tvalid  <= 0;
    s_tuser   <= 0;
    s_tdata   <= '0;
    cfg_valid <= 0;
    cfg_index <= REG_GATE_SHIFT;
    cfg_data  <= '0;
    rst       <= 1;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // fill every address the network reads
    for (int a = 0; a < USED; a++)
      load(a, a < 192 ? int'($urandom_range(0, 262144)) - 131072
                      : int'($urandom_range(0, 16384)) - 8192);

    // directed: field extremes and special cases
    evaluate(0, 0, 0, 65536);
    evaluate(8388607, 8388607, 8388607, 24'hFFFFFF);
    evaluate(-8388608, -8388608, -8388608, 0);
    evaluate(8388607, -8388608, 65536, 65536);
    evaluate(13107, 13107, -65536, 131072);
    load(S2B_A, 8388607);
    evaluate(65536, 0, 131072, 24'hFFFFFF);
    load(T2W_A, -8388608);
    evaluate(-65536, 65536, 196608, 24'hFFFFFF);
    load(32767, 8388607);
    load(USED, -8388608);
    evaluate(32768, 32768, 98304, 65536);
    settle();

    write_reg(REG_GATE_SHIFT, -8388608);
    write_reg(REG_GATE_INV, 24'hFFFFFF);
    write_reg(REG_DRAIN_INV, 24'hFFFFFF);
    write_reg(REG_CUR_SCALE, 32'h7FFFFFFF);
    repeat (3) rand_eval();
    settle();

    write_reg(REG_GATE_SHIFT, 8388607);
    write_reg(REG_GATE_INV, 0);
    write_reg(REG_DRAIN_INV, 0);
    write_reg(REG_CUR_SCALE, 0);
    repeat (2) rand_eval();
    settle();

    write_reg(REG_GATE_SHIFT, int'($urandom_range(0, 131072)) - 65536);
    write_reg(REG_GATE_INV, $urandom_range(0, 327680));
    write_reg(REG_DRAIN_INV, $urandom_range(0, 327680));
    write_reg(REG_CUR_SCALE, $urandom_range(0, 32'h7FFFFFFF));

    // long receiver hold-off while evaluations keep coming
    hold_go = 1;
    repeat (3) rand_eval();

    // random mix of loads and evaluations
    for (int n = 0; n < 100; n++) begin
      case ($urandom_range(0, 9))
        0, 1:    rand_eval();
        2:       load($urandom_range(0, 32767), $urandom_range(0, 24'hFFFFFF));
        default: load($urandom_range(0, USED - 1), int'($urandom_range(0, 16384)) - 8192);
      endcase
    end
    settle();

    write_reg(REG_GATE_SHIFT, 13107);
    write_reg(REG_GATE_INV, 163840);
    write_reg(REG_DRAIN_INV, 218453);
    write_reg(REG_CUR_SCALE, 30006320);
    repeat (2) rand_eval();
    settle();
    repeat (50) @(posedge clk);

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #30ms;
    $display("Verification failed");
    $finish;
  end
endmodule
